@@ rtl/lia_pkg.sv @@
// Package for the long integer ALU: opcodes, widths, queue depth and the transaction item type.
// No dependencies.
`timescale 1ns / 1ps
package lia_pkg;
    localparam int DataWidth = 64;
    localparam int OpWidth   = 4;
    localparam int QueueDepth = 4;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_REM = 4'd4,
        OP_NEG = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7, OP_XOR = 4'd8, OP_SHL = 4'd9,
        OP_SHR = 4'd10, OP_USHR = 4'd11, OP_CMP = 4'd12, OP_TOINT = 4'd13
    } t_op;

    typedef struct packed {
        logic [3:0]           op;
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
    } t_item;
endpackage

@@ rtl/lia_front.sv @@
// Front end: accepts transactions, holds them in a small queue for the back end.
// Depends on lia_pkg.
`timescale 1ns / 1ps
module lia_front #(
    parameter int DEPTH = lia_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lia_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lia_pkg::t_item  o_item
);
    import lia_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

@@ rtl/lia_back.sv @@
// Back end: executes one operation per cycle; divider pipelined one bit per stage.
// Depends on lia_pkg.
`timescale 1ns / 1ps
module lia_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  lia_pkg::t_item                i_item,
    output logic                          o_valid,
    output logic [lia_pkg::DataWidth-1:0] o_result,
    output logic                          o_dz
);
    import lia_pkg::*;
    localparam int W = DataWidth;
    localparam int L = W + 4;

    // stage 0: decode, simple ops, magnitudes, partial products
    logic [W-1:0] a, b, simple, ma, mb;
    logic [5:0] s;
    always_comb begin
        a = i_item.a; b = i_item.b; s = b[5:0];
        ma = a[W-1] ? -a : a;
        mb = b[W-1] ? -b : b;
        unique case (i_item.op)
            OP_ADD:   simple = a + b;
            OP_SUB:   simple = a - b;
            OP_NEG:   simple = -a;
            OP_AND:   simple = a & b;
            OP_OR:    simple = a | b;
            OP_XOR:   simple = a ^ b;
            OP_SHL:   simple = a << s;
            OP_SHR:   simple = W'($signed(a) >>> s);
            OP_USHR:  simple = a >> s;
            OP_CMP:   simple = ($signed(a) > $signed(b)) ? W'(1) :
                               (($signed(a) < $signed(b)) ? '1 : '0);
            OP_TOINT: simple = {{32{a[31]}}, a[31:0]};
            default:  simple = '0;
        endcase
    end

    logic          r_v   [L];
    logic [3:0]    r_op  [W+2];
    logic [W-1:0]  r_res [L];
    logic          r_sq  [W+2];
    logic          r_sr  [W+2];
    logic          r_dz  [L];
    logic [W-1:0]  r_q   [W+2];
    logic [W-1:0]  r_r   [W+2];
    logic [W-1:0]  r_d   [W+2];
    logic [W-1:0]  r_p0, r_p1, r_p2;

    // stage 0 register
    always_ff @(posedge i_clk) begin
        r_op[0]  <= i_item.op;
        r_res[0] <= simple;
        r_sq[0]  <= a[W-1] ^ b[W-1];
        r_sr[0]  <= a[W-1];
        r_dz[0]  <= (b == '0) && (i_item.op == OP_DIV || i_item.op == OP_REM);
        r_q[0]   <= ma;
        r_r[0]   <= '0;
        r_d[0]   <= mb;
        r_p0     <= W'(a[31:0] * b[31:0]);
        r_p1     <= W'(a[31:0] * b[63:32]);
        r_p2     <= W'(a[63:32] * b[31:0]);
    end

    // stage 1: combine product
    always_ff @(posedge i_clk) begin
        r_op[1]  <= r_op[0];
        r_res[1] <= (r_op[0] == OP_MUL) ? r_p0 + {r_p1[31:0] + r_p2[31:0], 32'd0} : r_res[0];
        r_sq[1] <= r_sq[0]; r_sr[1] <= r_sr[0]; r_dz[1] <= r_dz[0];
        r_q[1] <= r_q[0]; r_r[1] <= r_r[0]; r_d[1] <= r_d[0];
    end

    // stages 2..65: restoring division, one quotient bit per stage
    for (genvar k = 2; k < W + 2; k++) begin : g_div
        logic [W:0] rem_sh, diff;
        always_comb begin
            rem_sh = {r_r[k-1], r_q[k-1][W-1]};
            diff   = rem_sh - {1'b0, r_d[k-1]};
        end
        always_ff @(posedge i_clk) begin
            r_op[k] <= r_op[k-1]; r_res[k] <= r_res[k-1];
            r_sq[k] <= r_sq[k-1]; r_sr[k] <= r_sr[k-1]; r_dz[k] <= r_dz[k-1];
            r_d[k]  <= r_d[k-1];
            if (!diff[W]) begin
                r_r[k] <= diff[W-1:0];
                r_q[k] <= {r_q[k-1][W-2:0], 1'b1};
            end else begin
                r_r[k] <= rem_sh[W-1:0];
                r_q[k] <= {r_q[k-1][W-2:0], 1'b0};
            end
        end
    end

    // stage 66: sign fix and select
    always_ff @(posedge i_clk) begin
        r_dz[W+2] <= r_dz[W+1];
        if (r_dz[W+1])
            r_res[W+2] <= '0;
        else if (r_op[W+1] == OP_DIV)
            r_res[W+2] <= r_sq[W+1] ? -r_q[W+1] : r_q[W+1];
        else if (r_op[W+1] == OP_REM)
            r_res[W+2] <= r_sr[W+1] ? -r_r[W+1] : r_r[W+1];
        else
            r_res[W+2] <= r_res[W+1];
    end

    // stage 67: output register
    always_ff @(posedge i_clk) begin
        r_res[W+3] <= r_res[W+2]; r_dz[W+3] <= r_dz[W+2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) r_v[i] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int i = 1; i < L; i++) r_v[i] <= r_v[i-1];
        end
    end

    assign o_valid  = r_v[L-1];
    assign o_result = r_res[L-1];
    assign o_dz     = r_dz[L-1];
endmodule

@@ rtl/long_integer_alu_unit.sv @@
// Top level of the long integer ALU: front queue feeding the pipelined back end.
// Depends on lia_pkg, lia_front, lia_back.
`timescale 1ns / 1ps
// Usage:
//   Raise start with i_op, i_operand_a, i_operand_b; the transaction is taken
//   on a clock edge where start is high and busy is low.
//   Results appear for exactly one cycle with o_valid high, in order, one per
//   transaction; o_divide_by_zero flags div/rem with a zero divisor.
//   Every operation takes the same path: through the front queue, then a
//   68-stage back end whose length is set by the divider, which resolves one
//   quotient bit per stage.
//   Throughput is one transaction per cycle; the back end never stalls since
//   the receiver cannot hold results off, so busy stays low in operation.
//   busy only rises if the queue fills, which cannot happen in steady state.
//   Synchronous active-low reset empties the queue and drops all in-flight
//   transactions; no result is produced for them.
module long_integer_alu_unit #(
    parameter int QUEUE_DEPTH = lia_pkg::QueueDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lia_pkg::OpWidth-1:0]   i_op,
    input  logic [lia_pkg::DataWidth-1:0] i_operand_a,
    input  logic [lia_pkg::DataWidth-1:0] i_operand_b,
    output logic                          o_valid,
    output logic [lia_pkg::DataWidth-1:0] o_result,
    output logic                          o_divide_by_zero
);
    import lia_pkg::*;
    t_item in_item, q_item;
    logic full, empty, push, pop;

    assign in_item = '{op: i_op, a: i_operand_a, b: i_operand_b};
    assign busy = full;
    assign push = start && !full;
    assign pop  = !empty;

    lia_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(in_item),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_item(q_item)
    );

    lia_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(pop), .i_item(q_item),
        .o_valid(o_valid), .o_result(o_result), .o_dz(o_divide_by_zero)
    );
endmodule
